// ===== hdl/tgni_pkg.sv =====
// Shared types, constants and neighbor offset tables of the toroidal grid neighbor indexer.
`timescale 1ns / 1ps

package tgni_pkg;

    // Field and register widths
    localparam int COL_W      = 16;
    localparam int ROW_W      = 8;
    localparam int IDX_W      = 16;
    localparam int SIDE_W     = 9;
    localparam int WEFF_W     = 2 * SIDE_W;
    localparam int STEP_W     = 4;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // Default grid side limit
    localparam int DEFAULT_MAX_SIDE = 256;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Neighborhood mode codes
    localparam logic [MODE_W-1:0] MODE_MOORE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_VN    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RING  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    typedef enum logic [1:0] {
        HOOD_MOORE,
        HOOD_VN,
        HOOD_RING
    } hood_t;

    typedef enum logic [1:0] {
        OFS_ZERO,
        OFS_PLUS,
        OFS_MINUS
    } ofs_t;

    typedef struct packed {
        ofs_t dc;
        ofs_t dr;
    } offset_t;

    // One classified request waiting for the back end
    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [WEFF_W-1:0] w_eff;
        logic [SIDE_W-1:0] h_eff;
        hood_t             hood;
        logic              bad;
    } job_t;

    // Step number of the final result of a run
    function automatic logic [STEP_W-1:0] hood_last_step(input hood_t hood);
        logic [STEP_W-1:0] last;
        unique case (hood)
            HOOD_VN:   last = 4'd4;
            HOOD_RING: last = 4'd2;
            default:   last = 4'd8;
        endcase
        return last;
    endfunction

    // Column and row offset of step k of a neighborhood
    function automatic offset_t hood_offset(input hood_t hood, input logic [STEP_W-1:0] k);
        offset_t ofs;
        ofs = '{dc: OFS_ZERO, dr: OFS_ZERO};
        unique case (hood)
            HOOD_VN: begin
                case (k)
                    4'd1:    ofs = '{dc: OFS_ZERO,  dr: OFS_PLUS};
                    4'd2:    ofs = '{dc: OFS_PLUS,  dr: OFS_ZERO};
                    4'd3:    ofs = '{dc: OFS_ZERO,  dr: OFS_MINUS};
                    4'd4:    ofs = '{dc: OFS_MINUS, dr: OFS_ZERO};
                    default: ofs = '{dc: OFS_ZERO,  dr: OFS_ZERO};
                endcase
            end
            HOOD_RING: begin
                case (k)
                    4'd0:    ofs = '{dc: OFS_MINUS, dr: OFS_ZERO};
                    4'd2:    ofs = '{dc: OFS_PLUS,  dr: OFS_ZERO};
                    default: ofs = '{dc: OFS_ZERO,  dr: OFS_ZERO};
                endcase
            end
            default: begin
                case (k)
                    4'd1:    ofs = '{dc: OFS_ZERO,  dr: OFS_PLUS};
                    4'd2:    ofs = '{dc: OFS_PLUS,  dr: OFS_PLUS};
                    4'd3:    ofs = '{dc: OFS_PLUS,  dr: OFS_ZERO};
                    4'd4:    ofs = '{dc: OFS_PLUS,  dr: OFS_MINUS};
                    4'd5:    ofs = '{dc: OFS_ZERO,  dr: OFS_MINUS};
                    4'd6:    ofs = '{dc: OFS_MINUS, dr: OFS_MINUS};
                    4'd7:    ofs = '{dc: OFS_MINUS, dr: OFS_ZERO};
                    4'd8:    ofs = '{dc: OFS_MINUS, dr: OFS_PLUS};
                    default: ofs = '{dc: OFS_ZERO,  dr: OFS_ZERO};
                endcase
            end
        endcase
        return ofs;
    endfunction

endpackage

// ===== hdl/tgni_front.sv =====
// Front end: configuration registers, grid size clamping and request classification.
`timescale 1ns / 1ps

module tgni_front
    import tgni_pkg::*;
#(
    parameter int MAX_SIDE = DEFAULT_MAX_SIDE
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COL_W-1:0]      s_col_pos,
    input  logic [ROW_W-1:0]      s_row_pos,
    input  logic                  q_full,
    output logic                  q_push,
    output job_t                  q_job
);

    localparam logic [SIDE_W-1:0] SIDE_CAP = SIDE_W'(MAX_SIDE);

    logic [MODE_W-1:0] mode_reg,   mode_next;
    logic [SIDE_W-1:0] width_reg,  width_next;
    logic [SIDE_W-1:0] height_reg, height_next;

    logic [SIDE_W-1:0] w_side;
    logic [SIDE_W-1:0] h_side;
    logic [WEFF_W-1:0] area;
    hood_t             hood;

    // Register writes; unknown indexes are dropped
    always_comb begin
        mode_next   = mode_reg;
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MODE:   mode_next   = cfg_wdata[MODE_W-1:0];
                REG_WIDTH:  width_next  = cfg_wdata[SIDE_W-1:0];
                REG_HEIGHT: height_next = cfg_wdata[SIDE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_MOORE;
            width_reg  <= SIDE_W'(1);
            height_reg <= SIDE_W'(1);
        end else begin
            mode_reg   <= mode_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // Zero acts as one, anything above the limit as the limit
    always_comb begin
        if (width_reg == '0)                 w_side = SIDE_W'(1);
        else if (int'(width_reg) > MAX_SIDE) w_side = SIDE_CAP;
        else                                 w_side = width_reg;
        if (height_reg == '0)                 h_side = SIDE_W'(1);
        else if (int'(height_reg) > MAX_SIDE) h_side = SIDE_CAP;
        else                                  h_side = height_reg;
    end

    assign area = WEFF_W'(w_side) * WEFF_W'(h_side);

    // Mode decode; the unused code runs as Moore
    always_comb begin
        unique case (mode_reg)
            MODE_VN:   hood = HOOD_VN;
            MODE_RING: hood = HOOD_RING;
            default:   hood = HOOD_MOORE;
        endcase
    end

    // Ring mode flattens the grid into one row
    always_comb begin
        q_job.col  = s_col_pos;
        q_job.row  = s_row_pos;
        q_job.hood = hood;
        if (hood == HOOD_RING) begin
            q_job.w_eff = area;
            q_job.h_eff = SIDE_W'(1);
        end else begin
            q_job.w_eff = WEFF_W'(w_side);
            q_job.h_eff = h_side;
        end
        q_job.bad = (WEFF_W'(s_col_pos) >= q_job.w_eff) ||
                    (SIDE_W'(s_row_pos) >= q_job.h_eff);
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

endmodule

// ===== hdl/tgni_queue.sv =====
// Short request queue between the front end and the back end.
`timescale 1ns / 1ps

module tgni_queue
    import tgni_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg,  count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)      count_next = count_reg + QCNT_W'(1);
        else if (pop && !push) count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== hdl/tgni_back.sv =====
// Back end: walks the head request's neighborhood, one result per cycle unless stalled.
`timescale 1ns / 1ps

module tgni_back
    import tgni_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             head_valid,
    input  job_t             head_job,
    output logic             pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [IDX_W-1:0] m_neighbor_index,
    output logic [COL_W-1:0] m_neighbor_col,
    output logic [ROW_W-1:0] m_neighbor_row,
    output logic             m_last_neighbor,
    output logic             m_bad_position
);

    logic [STEP_W-1:0] step_reg, step_next;
    logic              valid_reg, valid_next;
    logic [IDX_W-1:0]  index_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic              last_reg;
    logic              bad_reg;

    offset_t           ofs;
    logic [STEP_W-1:0] last_step;
    logic              run_end;
    logic              advance;
    logic [WEFF_W-1:0] c_wrap;
    logic [WEFF_W-1:0] r_wrap;
    logic [WEFF_W-1:0] row_base;
    logic [WEFF_W-1:0] idx_sum;

    // Step one coordinate with wrap at both edges
    function automatic logic [WEFF_W-1:0] wrap_axis(input logic [WEFF_W-1:0] pos,
                                                    input ofs_t d,
                                                    input logic [WEFF_W-1:0] size);
        logic [WEFF_W-1:0] res;
        case (d)
            OFS_MINUS: res = (pos == '0) ? size - WEFF_W'(1) : pos - WEFF_W'(1);
            OFS_PLUS:  res = (pos + WEFF_W'(1) >= size) ? '0 : pos + WEFF_W'(1);
            default:   res = pos;
        endcase
        return res;
    endfunction

    assign ofs       = hood_offset(head_job.hood, step_reg);
    assign last_step = hood_last_step(head_job.hood);
    assign run_end   = head_job.bad || (step_reg == last_step);

    // Output register takes a new result whenever it is empty or being drained
    assign advance = head_valid && (!valid_reg || m_ready);
    assign pop     = advance && run_end;

    // Neighbor position; in ring mode the row is always zero
    assign c_wrap   = wrap_axis(WEFF_W'(head_job.col), ofs.dc, head_job.w_eff);
    assign r_wrap   = wrap_axis(WEFF_W'(head_job.row), ofs.dr, WEFF_W'(head_job.h_eff));
    assign row_base = WEFF_W'(r_wrap[SIDE_W-1:0]) * WEFF_W'(head_job.w_eff[SIDE_W-1:0]);
    assign idx_sum  = row_base + c_wrap;

    // Step counter and output valid
    always_comb begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (advance) begin
            step_next  = run_end ? '0 : step_reg + STEP_W'(1);
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    // Result payload; an out-of-grid position gives a single zeroed result
    always_ff @(posedge aclk) begin
        if (advance) begin
            if (head_job.bad) begin
                index_reg <= '0;
                col_reg   <= '0;
                row_reg   <= '0;
            end else begin
                index_reg <= idx_sum[IDX_W-1:0];
                col_reg   <= c_wrap[COL_W-1:0];
                row_reg   <= r_wrap[ROW_W-1:0];
            end
            last_reg <= run_end;
            bad_reg  <= head_job.bad;
        end
    end

    assign m_valid          = valid_reg;
    assign m_neighbor_index = index_reg;
    assign m_neighbor_col   = col_reg;
    assign m_neighbor_row   = row_reg;
    assign m_last_neighbor  = last_reg;
    assign m_bad_position   = bad_reg;

    // Step never runs past the end of the head request's neighborhood
    a_step_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid |-> (step_reg <= last_step))
        else $error("step counter beyond neighborhood size");

    // An out-of-grid request is handled in its first step
    a_bad_first_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_valid && head_job.bad) |-> (step_reg == '0))
        else $error("bad position request reached a later step");

    // Error result always closes its run with zeroed index and column
    a_bad_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && bad_reg) |-> (last_reg && index_reg == '0 && col_reg == '0))
        else $error("bad position result not final or not zeroed");

endmodule

// ===== hdl/toroidal_grid_neighbor_indexer_core.sv =====
// Top level of the toroidal grid neighbor indexer.
`timescale 1ns / 1ps

// Each accepted cell position produces its neighborhood as a burst of results, one per
// cycle while m_ready does not stall the output: 9 for Moore (mode 0 and the unused
// mode 3), 5 for von Neumann, 3 for ring, and a single flagged result when the position
// lies outside the grid. The result rate is set by the back-end sequencer, which emits
// one neighbor per cycle through its output register. The first result of an item is
// held in a queue entry and then in the output register. A two-entry queue between the
// classifying front end and the sequencer lets new positions be accepted while a burst is
// still in progress or stalled. Grid sides of zero act as one and sides above MAX_SIDE act
// as MAX_SIDE; in ring mode the grid is one row of width times height cells and row_pos
// must be zero. Configuration writes take effect on the next cycle and are to be made only
// with no request in flight.
module toroidal_grid_neighbor_indexer_core
    import tgni_pkg::*;
#(
    parameter int MAX_SIDE = DEFAULT_MAX_SIDE
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COL_W-1:0]      s_col_pos,
    input  logic [ROW_W-1:0]      s_row_pos,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [IDX_W-1:0]      m_neighbor_index,
    output logic [COL_W-1:0]      m_neighbor_col,
    output logic [ROW_W-1:0]      m_neighbor_row,
    output logic                  m_last_neighbor,
    output logic                  m_bad_position
);

    logic q_full;
    logic q_push;
    job_t q_job;
    logic q_pop;
    logic q_head_valid;
    job_t q_head_job;

    // Classification and configuration
    tgni_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_col_pos (s_col_pos),
        .s_row_pos (s_row_pos),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (q_job)
    );

    // Request queue
    tgni_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_job   (q_head_job)
    );

    // Neighbor sequencer and output register
    tgni_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .head_valid       (q_head_valid),
        .head_job         (q_head_job),
        .pop              (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_neighbor_index (m_neighbor_index),
        .m_neighbor_col   (m_neighbor_col),
        .m_neighbor_row   (m_neighbor_row),
        .m_last_neighbor  (m_last_neighbor),
        .m_bad_position   (m_bad_position)
    );

endmodule

// ===== dv/toroidal_grid_neighbor_indexer_core_tb.sv =====
// Self-checking testbench for the toroidal grid neighbor indexer core.
`timescale 1ns / 1ps

module toroidal_grid_neighbor_indexer_core_tb;
    import tgni_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 12;

    // One neighbor result as seen on the result channel
    typedef struct {
        logic [IDX_W-1:0] nb_index;
        logic [COL_W-1:0] nb_col;
        logic [ROW_W-1:0] nb_row;
        logic             nb_last;
        logic             nb_bad;
    } neighbor_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [COL_W-1:0]      s_col_pos = '0;
    logic [ROW_W-1:0]      s_row_pos = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [IDX_W-1:0]      m_neighbor_index;
    logic [COL_W-1:0]      m_neighbor_col;
    logic [ROW_W-1:0]      m_neighbor_row;
    logic                  m_last_neighbor;
    logic                  m_bad_position;

    // Shadow copy of the configuration registers
    logic [MODE_W-1:0]     grid_mode_q = MODE_MOORE;
    logic [SIDE_W-1:0]     grid_w_q    = 9'd1;
    logic [SIDE_W-1:0]     grid_h_q    = 9'd1;

    neighbor_t pending_neighbors[$];
    int        mismatch_count = 0;
    int        cycle_count    = 0;
    int        tx_idle_pct    = 0;
    int        rx_stall_pct   = 0;
    int        rx_hold_left   = 0;

    toroidal_grid_neighbor_indexer_core i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_col_pos        (s_col_pos),
        .s_row_pos        (s_row_pos),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_neighbor_index (m_neighbor_index),
        .m_neighbor_col   (m_neighbor_col),
        .m_neighbor_row   (m_neighbor_row),
        .m_last_neighbor  (m_last_neighbor),
        .m_bad_position   (m_bad_position)
    );

    // 50 MHz clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Run watchdog
    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_neighbors.size());
            $display("** toroidal_grid_neighbor_indexer_core: FAILED **");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR %0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        mismatch_count = mismatch_count + 1;
    endtask

    // Grid extent after side clamping; ring mode flattens to one row
    function automatic void effective_extent(output int w, output int h);
        w = (grid_w_q == 0) ? 1 : ((grid_w_q > DEFAULT_MAX_SIDE) ? DEFAULT_MAX_SIDE : grid_w_q);
        h = (grid_h_q == 0) ? 1 : ((grid_h_q > DEFAULT_MAX_SIDE) ? DEFAULT_MAX_SIDE : grid_h_q);
        if (grid_mode_q == MODE_RING) begin
            w = w * h;
            h = 1;
        end
    endfunction

    // Toroidal step of one axis
    function automatic int wrap_axis(input int pos, input int d, input int size);
        if (d < 0) return (pos == 0) ? size - 1 : pos - 1;
        if (d > 0) return (pos + 1 >= size) ? 0 : pos + 1;
        return pos;
    endfunction

    // Expected burst for one accepted cell position
    function automatic void predict_neighborhood(input logic [COL_W-1:0] col,
                                                 input logic [ROW_W-1:0] row);
        int        w, h, n, dc, dr, c, r;
        neighbor_t nb;
        effective_extent(w, h);
        if (grid_mode_q == MODE_VN) n = 5;
        else if (grid_mode_q == MODE_RING) n = 3;
        else n = 9;
        // outside the grid: single flagged result
        if (int'(col) >= w || int'(row) >= h) begin
            nb = '{nb_index: '0, nb_col: '0, nb_row: '0, nb_last: 1'b1, nb_bad: 1'b1};
            pending_neighbors.push_back(nb);
            return;
        end
        for (int k = 0; k < n; k++) begin
            dc = 0;
            dr = 0;
            if (grid_mode_q == MODE_VN) begin
                case (k)
                    1: dr = 1;
                    2: dc = 1;
                    3: dr = -1;
                    4: dc = -1;
                    default: ;
                endcase
            end else if (grid_mode_q == MODE_RING) begin
                case (k)
                    0: dc = -1;
                    2: dc = 1;
                    default: ;
                endcase
            end else begin
                // Moore order, also used for the unused mode code
                case (k)
                    1: dr = 1;
                    2: begin dc = 1;  dr = 1;  end
                    3: dc = 1;
                    4: begin dc = 1;  dr = -1; end
                    5: dr = -1;
                    6: begin dc = -1; dr = -1; end
                    7: dc = -1;
                    8: begin dc = -1; dr = 1;  end
                    default: ;
                endcase
            end
            c = wrap_axis(int'(col), dc, w);
            r = wrap_axis(int'(row), dr, h);
            nb.nb_index = IDX_W'(r * w + c);
            nb.nb_col   = COL_W'(c);
            nb.nb_row   = ROW_W'(r);
            nb.nb_last  = (k == n - 1);
            nb.nb_bad   = 1'b0;
            pending_neighbors.push_back(nb);
        end
    endfunction

    // Result channel ready, with random stalls and long hold-offs
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left = rx_hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Compare each result with the oldest expected neighbor
    always @(posedge aclk) begin : check_results
        neighbor_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_neighbors.size() == 0) begin
                report_mismatch("unexpected result, index", int'(m_neighbor_index), 0);
            end else begin
                want = pending_neighbors.pop_front();
                if (m_neighbor_index !== want.nb_index)
                    report_mismatch("neighbor_index", int'(m_neighbor_index),
                                    int'(want.nb_index));
                if (m_neighbor_col !== want.nb_col)
                    report_mismatch("neighbor_col", int'(m_neighbor_col), int'(want.nb_col));
                if (m_neighbor_row !== want.nb_row)
                    report_mismatch("neighbor_row", int'(m_neighbor_row), int'(want.nb_row));
                if (m_last_neighbor !== want.nb_last)
                    report_mismatch("last_neighbor", int'(m_last_neighbor),
                                    int'(want.nb_last));
                if (m_bad_position !== want.nb_bad)
                    report_mismatch("bad_position", int'(m_bad_position), int'(want.nb_bad));
            end
        end
    end

    // Offer one cell request; valid stays high across back-to-back requests
    task automatic send_cell(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        s_valid   <= 1'b1;
        s_col_pos <= col;
        s_row_pos <= row;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predict_neighborhood(col, row);
    endtask

    // Stop offering and wait for every expected result plus the pipeline tail
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_neighbors.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // Write all three registers back to back; block must be idle
    task automatic set_grid(input logic [CFG_DATA_W-1:0] mode_val,
                            input logic [CFG_DATA_W-1:0] w_val,
                            input logic [CFG_DATA_W-1:0] h_val);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_MODE;
        cfg_wdata <= mode_val;
        @(posedge aclk);
        cfg_index <= REG_WIDTH;
        cfg_wdata <= w_val;
        @(posedge aclk);
        cfg_index <= REG_HEIGHT;
        cfg_wdata <= h_val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        grid_mode_q = mode_val[MODE_W-1:0];
        grid_w_q    = w_val;
        grid_h_q    = h_val;
    endtask

    // Side values weighted toward the clamp edges and small wrapping grids
    function automatic logic [CFG_DATA_W-1:0] pick_side();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return CFG_DATA_W'(1);
            2:       return CFG_DATA_W'(2);
            3:       return CFG_DATA_W'(DEFAULT_MAX_SIDE);
            4:       return CFG_DATA_W'($urandom_range(DEFAULT_MAX_SIDE + 1, 511));
            5:       return CFG_DATA_W'($urandom_range(3, 255));
            default: return CFG_DATA_W'($urandom_range(3, 12));
        endcase
    endfunction

    // In-grid coordinate, often on an edge
    function automatic logic [COL_W-1:0] pick_coord(input int size);
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return COL_W'(size - 1);
            default: return COL_W'($urandom_range(0, size - 1));
        endcase
    endfunction

    // Reset values: 1x1 Moore grid, every offset folds onto cell 0
    task automatic test_reset_state();
        send_cell(16'd0, 8'd0);
        send_cell(16'd1, 8'd0);
        send_cell(16'd0, 8'd1);
        drain_results();
    endtask

    task automatic test_moore_edges();
        set_grid(CFG_DATA_W'(MODE_MOORE), 9'd256, 9'd256);
        send_cell(16'd0, 8'd0);
        send_cell(16'd255, 8'd255);
        send_cell(16'd0, 8'd255);
        send_cell(16'd255, 8'd0);
        send_cell(16'd256, 8'd0);
        send_cell(16'hFFFF, 8'hFF);
        drain_results();
        // zero width acts as one, oversize height clamps
        set_grid(CFG_DATA_W'(MODE_MOORE), 9'd0, 9'd511);
        send_cell(16'd0, 8'd128);
        drain_results();
    endtask

    task automatic test_von_neumann_edges();
        set_grid(CFG_DATA_W'(MODE_VN), 9'd5, 9'd3);
        send_cell(16'd4, 8'd2);
        send_cell(16'd0, 8'd0);
        send_cell(16'd2, 8'd1);
        send_cell(16'd5, 8'd0);
        send_cell(16'd0, 8'd3);
        drain_results();
    endtask

    task automatic test_ring_edges();
        // flattened row of 65536 cells
        set_grid(CFG_DATA_W'(MODE_RING), 9'd256, 9'd256);
        send_cell(16'hFFFF, 8'd0);
        send_cell(16'd0, 8'd0);
        send_cell(16'd0, 8'd1);
        send_cell(16'd1234, 8'hFF);
        drain_results();
        set_grid(CFG_DATA_W'(MODE_RING), 9'd3, 9'd1);
        send_cell(16'd2, 8'd0);
        send_cell(16'd3, 8'd0);
        drain_results();
    endtask

    task automatic test_unused_mode_and_narrow();
        // unused mode code with upper data bits set behaves as Moore
        set_grid(9'h1FF, 9'd2, 9'd2);
        send_cell(16'd1, 8'd1);
        send_cell(16'd0, 8'd0);
        drain_results();
        set_grid(CFG_DATA_W'(MODE_RING), 9'd1, 9'd1);
        send_cell(16'd0, 8'd0);
        drain_results();
    endtask

    // Mostly in-grid positions with a new random grid every 25 requests
    task automatic test_random_traffic(input int n_items, input int tx_pct, input int rx_pct);
        int               w, h;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        for (int i = 0; i < n_items; i++) begin
            if (i % 25 == 0) begin
                drain_results();
                set_grid(CFG_DATA_W'($urandom_range(0, 3)), pick_side(), pick_side());
            end
            effective_extent(w, h);
            if ($urandom_range(0, 9) == 0) begin
                col = COL_W'($urandom());
                row = ROW_W'($urandom());
            end else begin
                col = pick_coord(w);
                row = ROW_W'(pick_coord(h));
            end
            send_cell(col, row);
        end
        drain_results();
    endtask

    // Receiver holds off long enough for the input side to back up
    task automatic test_input_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        set_grid(CFG_DATA_W'(MODE_MOORE), 9'd16, 9'd16);
        rx_hold_left = 300;
        for (int i = 0; i < 15; i++)
            send_cell(pick_coord(16), ROW_W'(pick_coord(16)));
        drain_results();
    endtask

    // Sender waits for each burst to complete before the next request
    task automatic test_drain_between_items();
        tx_idle_pct  = 0;
        rx_stall_pct = 30;
        set_grid(CFG_DATA_W'(MODE_VN), 9'd7, 9'd9);
        for (int i = 0; i < 10; i++) begin
            send_cell(pick_coord(7), ROW_W'(pick_coord(9)));
            drain_results();
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_moore_edges();
        test_von_neumann_edges();
        test_ring_edges();
        test_unused_mode_and_narrow();
        test_random_traffic(80, 0, 0);
        test_random_traffic(70, 87, 0);
        test_random_traffic(70, 0, 87);
        test_random_traffic(70, 11, 11);
        test_input_backpressure();
        test_drain_between_items();

        drain_results();
        if (mismatch_count == 0 && pending_neighbors.size() == 0) begin
            $display("** toroidal_grid_neighbor_indexer_core: PASSED **");
        end else begin
            $display("** toroidal_grid_neighbor_indexer_core: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/tgni_pkg.sv
hdl/tgni_front.sv
hdl/tgni_queue.sv
hdl/tgni_back.sv
hdl/toroidal_grid_neighbor_indexer_core.sv
dv/toroidal_grid_neighbor_indexer_core_tb.sv
